/* rtl/assert_macros.svh */
// shared assertion shorthands, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/aesp_pkg.sv */
`default_nettype none

package aesp_pkg;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // register indexes, taken from the word-aligned address bit
    localparam logic REG_TS_MODE = 1'b0;
    localparam logic REG_UNWRAP  = 1'b1;

    typedef enum logic [1:0] {
        TS_NONE  = 2'd0,
        TS_TWO   = 2'd1,
        TS_THREE = 2'd2,
        TS_FOUR  = 2'd3
    } ts_mode_t;

    localparam ts_mode_t TS_MODE_RESET = TS_THREE;
    localparam logic     UNWRAP_RESET  = 1'b1;

    // wrap added to the delta when the device time runs backwards
    localparam logic [32:0] WRAP_NONE  = 33'h0_0000_0000;
    localparam logic [32:0] WRAP_TWO   = 33'h0_0001_0000;
    localparam logic [32:0] WRAP_THREE = 33'h0_0100_0000;
    localparam logic [32:0] WRAP_FOUR  = 33'h1_0000_0000;

    typedef enum logic [2:0] {
        PH_SYNC   = 3'd0,
        PH_COLUMN = 3'd1,
        PH_STAMP1 = 3'd2,
        PH_STAMP2 = 3'd3,
        PH_STAMP3 = 3'd4,
        PH_STAMP4 = 3'd5
    } phase_t;

    typedef struct packed {
        ts_mode_t ts_mode;
        logic     unwrap;
    } cfg_t;

    typedef struct packed {
        logic [6:0]  x;
        logic [6:0]  y;
        logic        polarity;
        logic [31:0] stamp;
        cfg_t        cfg;
    } event_t;

endpackage

`default_nettype wire

/* rtl/address_event_stream_parser.sv */
`default_nettype none

// Decodes a sensor byte stream of address events (1yyyyyyy, pxxxxxxx, then 0, 2, 3 or 4
// big-endian timestamp bytes) into one word per event: column, row, polarity and a
// 64-bit time that is either the raw device timestamp or the unwrapped host time.
// One byte is taken every cycle unless byte_ready is low; the byte-phase parser works
// on the byte as it is accepted and loads a completed event into the event register,
// and the unwrap stage (one 33-bit delta and one 64-bit add) moves it into the output
// register, which drives the event port. A stalled output holds back
// bytes only once both the event register and the output register are full, and then
// every byte waits, whatever its place in an event. No clearing pass after reset.
// Registers over the APB port: 0x0 timestamp mode (reset 2), 0x4 unwrap enable (reset 1).
module address_event_stream_parser
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [aesp_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [aesp_pkg::DATA_W-1:0]   pwdata,
    output logic      [aesp_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          byte_valid,
    output logic                               byte_ready,
    input  wire logic [7:0]                    data_byte,
    output logic                               event_valid,
    input  wire logic                          event_ready,
    output logic [6:0]                         event_x,
    output logic [6:0]                         event_y,
    output logic                               event_polarity,
    output logic [63:0]                        event_time
);

    aesp_pkg::cfg_t   cfg;
    aesp_pkg::event_t evt;
    logic             evt_valid;
    logic             evt_ready;

    assign pready = 1'b1;

    aesp_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    aesp_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .data_byte  (data_byte),
        .evt_valid  (evt_valid),
        .evt_ready  (evt_ready),
        .evt        (evt)
    );

    aesp_unwrap u_unwrap
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .evt_valid      (evt_valid),
        .evt_ready      (evt_ready),
        .evt            (evt),
        .event_valid    (event_valid),
        .event_ready    (event_ready),
        .event_x        (event_x),
        .event_y        (event_y),
        .event_polarity (event_polarity),
        .event_time     (event_time)
    );

endmodule

`default_nettype wire

/* rtl/aesp_regs.sv */
`default_nettype none

module aesp_regs
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [aesp_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [aesp_pkg::DATA_W-1:0]   pwdata,
    output logic      [aesp_pkg::DATA_W-1:0]   prdata,
    output aesp_pkg::cfg_t                     cfg
);

    aesp_pkg::ts_mode_t ts_mode_reg;
    logic               unwrap_reg;
    logic               reg_sel;
    logic               wr_en;

    assign reg_sel = paddr[aesp_pkg::ADDR_W-1];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_mode_reg <= aesp_pkg::TS_MODE_RESET;
            unwrap_reg  <= aesp_pkg::UNWRAP_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                aesp_pkg::REG_TS_MODE: ts_mode_reg <= aesp_pkg::ts_mode_t'(pwdata[1:0]);
                aesp_pkg::REG_UNWRAP:  unwrap_reg  <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            aesp_pkg::REG_TS_MODE: prdata = {30'b0, ts_mode_reg};
            aesp_pkg::REG_UNWRAP:  prdata = {31'b0, unwrap_reg};
        endcase
    end

    assign cfg.ts_mode = ts_mode_reg;
    assign cfg.unwrap  = unwrap_reg;

endmodule

`default_nettype wire

/* rtl/aesp_parser.sv */
`default_nettype none

module aesp_parser
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire aesp_pkg::cfg_t  cfg,
    input  wire logic            byte_valid,
    output logic                 byte_ready,
    input  wire logic [7:0]      data_byte,
    output logic                 evt_valid,
    input  wire logic            evt_ready,
    output aesp_pkg::event_t     evt
);

    aesp_pkg::phase_t phase_reg;
    aesp_pkg::phase_t phase_next;
    logic [6:0]       row_reg;
    logic [6:0]       row_next;
    logic [7:0]       col_reg;
    logic [7:0]       col_next;
    logic [31:0]      acc_reg;
    logic [31:0]      acc_next;
    logic [31:0]      acc_shift;
    logic [31:0]      stamp;
    logic [2:0]       need;
    logic [2:0]       gathered;
    logic             done;
    logic             fire;
    logic             evt_valid_reg;
    aesp_pkg::event_t evt_reg;

    assign byte_ready = !evt_valid_reg || evt_ready;
    assign fire       = byte_valid && byte_ready;
    assign acc_shift  = {acc_reg[23:0], data_byte};
    assign gathered   = 3'(phase_reg) - 3'd1;

    always_comb
    begin
        unique case (cfg.ts_mode)
            aesp_pkg::TS_NONE:  need = 3'd0;
            aesp_pkg::TS_TWO:   need = 3'd2;
            aesp_pkg::TS_THREE: need = 3'd3;
            aesp_pkg::TS_FOUR:  need = 3'd4;
        endcase
    end

    // timestamp is the low bytes of the accumulator, as many as the mode needs
    always_comb
    begin
        unique case (cfg.ts_mode)
            aesp_pkg::TS_NONE:  stamp = 32'b0;
            aesp_pkg::TS_TWO:   stamp = {16'b0, acc_shift[15:0]};
            aesp_pkg::TS_THREE: stamp = {8'b0, acc_shift[23:0]};
            aesp_pkg::TS_FOUR:  stamp = acc_shift;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        acc_next   = acc_reg;
        done       = 1'b0;
        unique case (phase_reg)
            aesp_pkg::PH_COLUMN:
            begin
                col_next = data_byte;
                if (cfg.ts_mode == aesp_pkg::TS_NONE)
                begin
                    done       = 1'b1;
                    phase_next = aesp_pkg::PH_SYNC;
                end
                else
                begin
                    phase_next = aesp_pkg::PH_STAMP1;
                end
            end
            aesp_pkg::PH_STAMP1, aesp_pkg::PH_STAMP2,
            aesp_pkg::PH_STAMP3, aesp_pkg::PH_STAMP4:
            begin
                acc_next = acc_shift;
                // a mode change mid-event can leave enough bytes already gathered
                if (gathered >= need)
                begin
                    done       = 1'b1;
                    phase_next = aesp_pkg::PH_SYNC;
                end
                else
                begin
                    phase_next = aesp_pkg::phase_t'(3'(phase_reg) + 3'd1);
                end
            end
            default:
            begin
                // hunting for the sync bit; unused codes behave the same
                phase_next = aesp_pkg::PH_SYNC;
                if (data_byte[7])
                begin
                    row_next   = data_byte[6:0];
                    acc_next   = 32'b0;
                    phase_next = aesp_pkg::PH_COLUMN;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= aesp_pkg::PH_SYNC;
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg <= phase_next;
            end
            if (byte_ready)
            begin
                evt_valid_reg <= fire && done;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            acc_reg <= acc_next;
        end
        if (fire && done)
        begin
            evt_reg.x        <= col_next[6:0];
            evt_reg.y        <= row_reg;
            evt_reg.polarity <= col_next[7];
            evt_reg.stamp    <= stamp;
            evt_reg.cfg      <= cfg;
        end
    end

    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

endmodule

`default_nettype wire

/* rtl/aesp_unwrap.sv */
`default_nettype none

module aesp_unwrap
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              evt_valid,
    output logic                   evt_ready,
    input  wire aesp_pkg::event_t  evt,
    output logic                   event_valid,
    input  wire logic              event_ready,
    output logic [6:0]             event_x,
    output logic [6:0]             event_y,
    output logic                   event_polarity,
    output logic [63:0]            event_time
);

    logic        out_valid_reg;
    logic [6:0]  x_reg;
    logic [6:0]  y_reg;
    logic        pol_reg;
    logic [63:0] host_reg;
    logic [63:0] host_next;
    logic [31:0] last_reg;
    logic        seen_reg;
    logic        xfer;
    logic [32:0] wrap;
    logic [32:0] diff;
    logic [33:0] back;
    logic [63:0] delta;
    logic [63:0] host_sum;

    assign evt_ready = !out_valid_reg || event_ready;
    assign xfer      = evt_valid && evt_ready;

    always_comb
    begin
        unique case (evt.cfg.ts_mode)
            aesp_pkg::TS_NONE:  wrap = aesp_pkg::WRAP_NONE;
            aesp_pkg::TS_TWO:   wrap = aesp_pkg::WRAP_TWO;
            aesp_pkg::TS_THREE: wrap = aesp_pkg::WRAP_THREE;
            aesp_pkg::TS_FOUR:  wrap = aesp_pkg::WRAP_FOUR;
        endcase
    end

    // diff sign bit set means the device time went backwards
    assign diff = {1'b0, evt.stamp} - {1'b0, last_reg};
    assign back = {1'b0, wrap} + {diff[32], diff};

    always_comb
    begin
        priority if (!seen_reg)
        begin
            delta = 64'b0;
        end
        else if (diff[32])
        begin
            delta = {{30{back[33]}}, back};
        end
        else
        begin
            delta = {31'b0, diff};
        end
    end

    assign host_sum  = (seen_reg ? host_reg : 64'b0) + delta;
    assign host_next = evt.cfg.unwrap ? host_sum : {32'b0, evt.stamp};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            host_reg      <= 64'b0;
            last_reg      <= 32'b0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            if (evt_ready)
            begin
                out_valid_reg <= evt_valid;
            end
            if (xfer)
            begin
                host_reg <= host_next;
                last_reg <= evt.stamp;
                seen_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            x_reg   <= evt.x;
            y_reg   <= evt.y;
            pol_reg <= evt.polarity;
        end
    end

    // host time only moves when a new word is loaded, so it doubles as the output time
    assign event_valid    = out_valid_reg;
    assign event_x        = x_reg;
    assign event_y        = y_reg;
    assign event_polarity = pol_reg;
    assign event_time     = host_reg;

endmodule

`default_nettype wire

/* rtl/aesp_checker.sv */
`default_nettype none

`include "assert_macros.svh"

module aesp_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        byte_valid,
    input wire logic        byte_ready,
    input wire logic        event_valid,
    input wire logic        event_ready,
    input wire logic [6:0]  event_x,
    input wire logic [6:0]  event_y,
    input wire logic        event_polarity,
    input wire logic [63:0] event_time
);

    // a word waiting on the output must not change under the consumer
    `ASSERT_NEXT(a_event_held, event_valid && !event_ready, event_valid && $stable(event_time) && $stable(event_x) && $stable(event_y) && $stable(event_polarity), "event word changed while stalled")

    // the byte side only stalls behind a full output register
    `ASSERT_NOW(a_stall_from_output, !byte_ready, event_valid && !event_ready, "byte input stalled with output free")

    // a fresh word comes out after the byte that completed it has passed the event and output registers
    `ASSERT_NOW(a_result_latency, $rose(event_valid), $past(byte_valid && byte_ready, 2), "event word without a completing byte")

endmodule

bind address_event_stream_parser aesp_checker u_aesp_checker (.*);

`default_nettype wire

/* dv/tb.sv */
`default_nettype none

module tb;

    localparam int RANDOM_ITEMS   = 1700;
    localparam int HOLD_CYCLES    = 500;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [6:0]  x;
        logic [6:0]  y;
        logic        polarity;
        logic [63:0] stamp;
    } parsed_event_t;

    logic                          clk;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [aesp_pkg::ADDR_W-1:0]   paddr = '0;
    logic [aesp_pkg::DATA_W-1:0]   pwdata = '0;
    logic [aesp_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          byte_valid = 1'b0;
    logic                          byte_ready;
    logic [7:0]                    data_byte = '0;
    logic                          event_valid;
    logic                          event_ready = 1'b0;
    logic [6:0]                    event_x;
    logic [6:0]                    event_y;
    logic                          event_polarity;
    logic [63:0]                   event_time;

    address_event_stream_parser dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .data_byte      (data_byte),
        .event_valid    (event_valid),
        .event_ready    (event_ready),
        .event_x        (event_x),
        .event_y        (event_y),
        .event_polarity (event_polarity),
        .event_time     (event_time)
    );

    // byte parser mirror, registers as they come out of reset
    aesp_pkg::ts_mode_t cur_mode = aesp_pkg::TS_MODE_RESET;
    logic               cur_unwrap = aesp_pkg::UNWRAP_RESET;
    aesp_pkg::phase_t   parse_phase = aesp_pkg::PH_SYNC;
    logic [6:0]    row_bits = '0;
    logic [7:0]    colpol_bits = '0;
    logic [31:0]   stamp_shift = '0;
    logic [63:0]   last_dev_time = '0;
    logic [63:0]   host_clock = '0;
    logic          seen_event = 1'b0;

    logic [7:0]    byte_q[$];
    parsed_event_t expected_events[$];

    logic          byte_taken = 1'b0;
    int unsigned   burst_left = 0;
    int unsigned   gap_left = 0;
    int unsigned   idle_cycles = 0;
    int unsigned   errors = 0;
    int unsigned   stream_bytes = 0;
    logic [31:0]   gen_stamp = '0;

    logic          hold_req = 1'b0;
    logic          hold_done = 1'b0;
    int unsigned   hold_cnt = 0;
    int unsigned   pattern_left = 0;
    int unsigned   stall_style = 0;

    task automatic decode_byte(input logic [7:0] b);
        int            need;
        logic          done;
        logic [63:0]   dev_time;
        logic [63:0]   delta;
        logic [63:0]   wrap;
        parsed_event_t ev;
        need = (cur_mode == aesp_pkg::TS_NONE) ? 0 : int'(cur_mode) + 1;
        done = 1'b0;
        case (parse_phase)
            aesp_pkg::PH_COLUMN:
            begin
                colpol_bits = b;
                if (need == 0)
                    done = 1'b1;
                else
                    parse_phase = aesp_pkg::PH_STAMP1;
            end
            aesp_pkg::PH_STAMP1, aesp_pkg::PH_STAMP2,
            aesp_pkg::PH_STAMP3, aesp_pkg::PH_STAMP4:
            begin
                stamp_shift = {stamp_shift[23:0], b};
                if (int'(parse_phase) - 1 >= need)
                    done = 1'b1;
                else
                    parse_phase = aesp_pkg::phase_t'(parse_phase + 3'd1);
            end
            default:
            begin
                // bytes without the sync bit are dropped while hunting
                parse_phase = aesp_pkg::PH_SYNC;
                if (b[7])
                begin
                    row_bits = b[6:0];
                    stamp_shift = '0;
                    parse_phase = aesp_pkg::PH_COLUMN;
                end
            end
        endcase
        if (done)
        begin
            if (need == 0)
                dev_time = '0;
            else if (need >= 4)
                dev_time = 64'(stamp_shift);
            else
                dev_time = 64'(stamp_shift) & ((64'd1 << (8 * need)) - 64'd1);
            case (cur_mode)
                aesp_pkg::TS_TWO:   wrap = 64'(aesp_pkg::WRAP_TWO);
                aesp_pkg::TS_THREE: wrap = 64'(aesp_pkg::WRAP_THREE);
                aesp_pkg::TS_FOUR:  wrap = 64'(aesp_pkg::WRAP_FOUR);
                default:            wrap = 64'(aesp_pkg::WRAP_NONE);
            endcase
            if (!seen_event)
            begin
                delta = '0;
                host_clock = '0;
            end
            else if (dev_time >= last_dev_time)
                delta = dev_time - last_dev_time;
            else
                delta = wrap + dev_time - last_dev_time;
            last_dev_time = dev_time;
            host_clock = host_clock + delta;
            seen_event = 1'b1;
            ev.x = colpol_bits[6:0];
            ev.y = row_bits;
            ev.polarity = colpol_bits[7];
            if (cur_unwrap)
                ev.stamp = host_clock;
            else
            begin
                ev.stamp = dev_time;
                host_clock = dev_time;
            end
            expected_events.push_back(ev);
            parse_phase = aesp_pkg::PH_SYNC;
        end
    endtask

    task automatic push_event(input logic [6:0] y, input logic pol, input logic [6:0] x,
                              input int n, input logic [31:0] stamp);
        byte_q.push_back({1'b1, y});
        byte_q.push_back({pol, x});
        for (int i = n - 1; i >= 0; i--)
            byte_q.push_back(stamp[8*i +: 8]);
        stream_bytes += 2 + n;
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == aesp_pkg::REG_TS_MODE)
            cur_mode = aesp_pkg::ts_mode_t'(value[1:0]);
        else
            cur_unwrap = value[0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input aesp_pkg::ts_mode_t mode, input logic unwrap);
        reg_write(aesp_pkg::REG_TS_MODE, 32'(mode));
        reg_write(aesp_pkg::REG_UNWRAP, 32'(unwrap));
    endtask

    // stream drained and every event seen, plus a margin for the unwrap stage
    task automatic wait_drained();
        while (!(byte_q.size() == 0 && !byte_valid && expected_events.size() == 0))
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // byte sender: bursts of random length with random gaps between them
    always @(negedge clk)
    begin
        if (!rst_n)
            byte_valid <= 1'b0;
        else if (byte_valid && !byte_taken)
            byte_valid <= 1'b1;
        else if (gap_left != 0)
        begin
            byte_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (byte_q.size() != 0)
        begin
            byte_valid <= 1'b1;
            data_byte <= byte_q.pop_front();
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 40);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end
            else
                burst_left <= burst_left - 1;
        end
        else
            byte_valid <= 1'b0;
    end

    // event receiver: stall pattern of its own, plus one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            event_ready <= 1'b0;
        else if (hold_cnt != 0)
        begin
            event_ready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end
        else if (hold_req && !hold_done)
        begin
            event_ready <= 1'b0;
            hold_cnt <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                stall_style <= $urandom_range(0, 3);
                pattern_left <= $urandom_range(50, 300);
            end
            else
                pattern_left <= pattern_left - 1;
            case (stall_style)
                0:       event_ready <= 1'b1;
                1:       event_ready <= 1'($urandom_range(0, 1));
                2:       event_ready <= ($urandom_range(0, 7) == 0);
                default: event_ready <= pattern_left[2];
            endcase
        end
    end

    always @(posedge clk)
    begin : monitor
        parsed_event_t want;
        parsed_event_t got;
        if (rst_n)
        begin
            if (event_valid && event_ready)
            begin
                got = '{event_x, event_y, event_polarity, event_time};
                if (expected_events.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("unexpected event x=%0d y=%0d p=%0d t=%0h",
                                 got.x, got.y, got.polarity, got.stamp);
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (got != want)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display("event mismatch: exp x=%0d y=%0d p=%0d t=%0h, got x=%0d y=%0d p=%0d t=%0h",
                                     want.x, want.y, want.polarity, want.stamp,
                                     got.x, got.y, got.polarity, got.stamp);
                    end
                end
            end
            // prediction after the check so an event never meets its own word
            if (byte_valid && byte_ready)
                decode_byte(data_byte);
            byte_taken <= byte_valid && byte_ready;
            if ((byte_valid && byte_ready) || (event_valid && event_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int                 n;
        int                 k;
        int                 events;
        aesp_pkg::ts_mode_t mode;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: three stamp bytes, unwrapped
        push_event(7'd0, 1'b0, 7'd0, 3, 32'h0);
        push_event(7'd127, 1'b1, 7'd127, 3, 32'hFF_FFFF);
        push_event(7'd5, 1'b0, 7'd9, 3, 32'h10);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'h7F);
        // event left half done across a mode change
        byte_q.push_back(8'hAA);
        byte_q.push_back(8'h55);
        byte_q.push_back(8'h12);
        wait_drained();
        set_config(aesp_pkg::TS_TWO, 1'b1);
        byte_q.push_back(8'h34);
        wait_drained();
        // no stamp: device time drops back to zero from a stale value
        set_config(aesp_pkg::TS_NONE, 1'b1);
        push_event(7'd3, 1'b1, 7'd4, 0, 32'h0);
        wait_drained();

        stream_bytes = 0;
        for (k = 0; stream_bytes < RANDOM_ITEMS; k++)
        begin
            if (k < 8)
                set_config(aesp_pkg::ts_mode_t'(3 - k % 4), k >= 4);
            else
                set_config(aesp_pkg::ts_mode_t'($urandom_range(0, 3)),
                           1'($urandom_range(0, 1)));
            if (k == 2)
                hold_req = 1'b1;
            mode = cur_mode;
            n = (mode == aesp_pkg::TS_NONE) ? 0 : int'(mode) + 1;
            events = $urandom_range(15, 50);
            for (int e = 0; e < events; e++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: gen_stamp += $urandom_range(0, 400);
                    6:                gen_stamp += $urandom;
                    7:                gen_stamp = $urandom;
                    8:                gen_stamp = '0;
                    default:          gen_stamp = '1;
                endcase
                case ($urandom_range(0, 19))
                    0:
                        byte_q.push_back(8'($urandom_range(0, 255)));
                    1:
                    begin
                        // truncated event, the next one lands out of step
                        byte_q.push_back({1'b1, 7'($urandom)});
                        for (int j = $urandom_range(0, n); j > 0; j--)
                            byte_q.push_back(8'($urandom));
                    end
                    default:
                        push_event(7'($urandom), 1'($urandom), 7'($urandom), n, gen_stamp);
                endcase
            end
            // sometimes leave an event open for the next mode
            if ($urandom_range(0, 2) == 0)
            begin
                byte_q.push_back({1'b1, 7'($urandom)});
                for (int j = $urandom_range(0, n); j > 0; j--)
                    byte_q.push_back(8'($urandom));
            end
            wait_drained();
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0 && expected_events.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/aesp_pkg.sv
rtl/aesp_regs.sv
rtl/aesp_parser.sv
rtl/aesp_unwrap.sv
rtl/address_event_stream_parser.sv
rtl/aesp_checker.sv
dv/tb.sv
